// ===== design/cfd_pkg.sv =====
package cfd_pkg;

  // Field widths
  localparam int ELEM_W  = 12;
  localparam int RES_W   = 50;
  localparam int ORDER_W = 3;

  // Defaults
  localparam int              MAX_ORDER_DEF = 4;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;

  // Controller to datapath / sequencer commands
  typedef struct packed {
    logic load;       // write one element into the store
    logic init;       // restart the permutation sequence, clear the sum
    logic fetch;      // read one element of the current term
    logic mul;        // multiply the fetched element into the term
    logic mul_first;  // first factor of a term
    logic acc;        // add or subtract the finished term
    logic step;       // advance the permutation sequencer
    logic emit;       // capture the determinant
  } cmd_t;

  // Sequencer to controller status
  typedef struct packed {
    logic fin;        // all permutations visited
    logic emit;       // the next step produces a new permutation
  } perm_sts_t;

endpackage

// ===== design/cfd_perm.sv =====
module cfd_perm #(
  parameter int MAX_ORDER = cfd_pkg::MAX_ORDER_DEF,
  parameter int CntW      = $clog2(MAX_ORDER + 1),
  parameter int IdxW      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfd_pkg::cmd_t     cmd_i,
  input  logic [CntW-1:0]   order_i,
  input  logic [IdxW-1:0]   row_i,
  output logic [IdxW-1:0]   col_o,
  output logic              neg_o,
  output cfd_pkg::perm_sts_t sts_o
);
  import cfd_pkg::*;

  logic [IdxW-1:0] perm_q [MAX_ORDER];
  logic [IdxW-1:0] perm_d [MAX_ORDER];
  logic [IdxW-1:0] c_q    [MAX_ORDER];
  logic [IdxW-1:0] c_d    [MAX_ORDER];
  logic [CntW-1:0] i_q, i_d;
  logic            neg_q, neg_d;
  logic [IdxW-1:0] i_idx;
  logic [IdxW-1:0] c_sel;
  logic [IdxW-1:0] swap_lo;
  logic            fin;
  logic            hit;

  // Heap's algorithm: one counter step per cycle while step is commanded, each swap flips the sign
  assign i_idx   = i_q[IdxW-1:0];
  assign c_sel   = c_q[i_idx];
  assign fin     = (i_q >= order_i);
  assign hit     = !fin && (CntW'(c_sel) < i_q);
  assign swap_lo = i_q[0] ? c_sel : '0;

  assign sts_o.fin  = fin;
  assign sts_o.emit = hit;
  assign col_o      = perm_q[row_i];
  assign neg_o      = neg_q;

  always_comb begin
    perm_d = perm_q;
    c_d    = c_q;
    i_d    = i_q;
    neg_d  = neg_q;
    if (cmd_i.init) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        perm_d[k] = IdxW'(k);
        c_d[k]    = '0;
      end
      i_d   = CntW'(1);
      neg_d = 1'b0;
    end else if (cmd_i.step && !fin) begin
      if (hit) begin
        perm_d[swap_lo] = perm_q[i_idx];
        perm_d[i_idx]   = perm_q[swap_lo];
        c_d[i_idx]      = c_sel + IdxW'(1);
        i_d             = CntW'(1);
        neg_d           = !neg_q;
      end else begin
        c_d[i_idx] = '0;
        i_d        = i_q + CntW'(1);
      end
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        perm_q[k] <= IdxW'(k);
        c_q[k]    <= '0;
      end
      i_q   <= CntW'(1);
      neg_q <= 1'b0;
    end else begin
      perm_q <= perm_d;
      c_q    <= c_d;
      i_q    <= i_d;
      neg_q  <= neg_d;
    end
  end

endmodule

// ===== design/cfd_dp.sv =====
module cfd_dp #(
  parameter int MAX_ORDER = cfd_pkg::MAX_ORDER_DEF,
  parameter int IdxW      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                              clk_i,
  input  cfd_pkg::cmd_t                     cmd_i,
  input  logic signed [cfd_pkg::ELEM_W-1:0] element_i,
  input  logic [IdxW-1:0]                   ld_row_i,
  input  logic [IdxW-1:0]                   ld_col_i,
  input  logic [IdxW-1:0]                   rd_row_i,
  input  logic [IdxW-1:0]                   rd_col_i,
  input  logic                              neg_i,
  output logic signed [cfd_pkg::RES_W-1:0]  det_o
);
  import cfd_pkg::*;

  logic signed [ELEM_W-1:0]       store_q [MAX_ORDER][MAX_ORDER];
  logic signed [ELEM_W-1:0]       elem_q;
  logic signed [RES_W-1:0]        prod_q;
  logic signed [RES_W-1:0]        acc_q;
  logic signed [RES_W-1:0]        res_q;
  logic signed [RES_W-1:0]        mul_a;
  logic signed [RES_W+ELEM_W-1:0] mul_full;

  // Multiply the running term by the fetched element, keep the low bits
  assign mul_a    = cmd_i.mul_first ? RES_W'(1) : prod_q;
  assign mul_full = mul_a * elem_q;
  assign det_o    = res_q;

  // Load elements, fetch, multiply and accumulate terms
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      store_q[ld_row_i][ld_col_i] <= element_i;
    end
    if (cmd_i.fetch) begin
      elem_q <= store_q[rd_row_i][rd_col_i];
    end
    if (cmd_i.mul) begin
      prod_q <= mul_full[RES_W-1:0];
    end
    if (cmd_i.init) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      acc_q <= neg_i ? (acc_q - prod_q) : (acc_q + prod_q);
    end
    if (cmd_i.emit) begin
      res_q <= acc_q;
    end
  end

endmodule

// ===== design/cfd_ctrl.sv =====
module cfd_ctrl #(
  parameter int MAX_ORDER = cfd_pkg::MAX_ORDER_DEF,
  parameter int CntW      = $clog2(MAX_ORDER + 1),
  parameter int IdxW      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cfd_pkg::ORDER_W-1:0]   cfg_data_i,
  input  cfd_pkg::perm_sts_t            sts_i,
  output cfd_pkg::cmd_t                 cmd_o,
  output logic [CntW-1:0]               order_o,
  output logic [IdxW-1:0]               ld_row_o,
  output logic [IdxW-1:0]               ld_col_o,
  output logic [IdxW-1:0]               rd_row_o,
  output logic                          done_o
);
  import cfd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_PROD = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_STEP = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [ORDER_W-1:0] order_q, order_d;
  logic [IdxW-1:0]    ld_row_q, ld_row_d;
  logic [IdxW-1:0]    ld_col_q, ld_col_d;
  logic [CntW-1:0]    row_q, row_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    n;
  logic [CntW-1:0]    n_m1;
  logic               req;
  logic               cfg_wr;

  // Clamp the configured order to 1..MAX_ORDER
  always_comb begin
    if (order_q == '0) begin
      n = CntW'(1);
    end else if (order_q > ORDER_W'(MAX_ORDER)) begin
      n = CntW'(MAX_ORDER);
    end else begin
      n = order_q[CntW-1:0];
    end
  end

  // Hold off a config write while an element request is offered
  assign n_m1        = n - CntW'(1);
  assign busy        = (state_q != S_IDLE);
  assign req         = start && !busy;
  assign cfg_ready_o = !busy && !start;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign order_o     = n;
  assign ld_row_o    = ld_row_q;
  assign ld_col_o    = ld_col_q;
  assign rd_row_o    = row_q[IdxW-1:0];
  assign done_o      = done_q;

  // Sequence load, term products, accumulation and permutation steps
  always_comb begin
    state_d  = state_q;
    order_d  = order_q;
    ld_row_d = ld_row_q;
    ld_col_d = ld_col_q;
    row_d    = row_q;
    done_d   = 1'b0;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (cfg_wr) begin
          order_d  = cfg_data_i;
          ld_row_d = '0;
          ld_col_d = '0;
        end else if (req) begin
          cmd_o.load = 1'b1;
          if (CntW'(ld_col_q) == n_m1) begin
            ld_col_d = '0;
            if (CntW'(ld_row_q) == n_m1) begin
              ld_row_d = '0;
              state_d  = S_INIT;
            end else begin
              ld_row_d = ld_row_q + IdxW'(1);
            end
          end else begin
            ld_col_d = ld_col_q + IdxW'(1);
          end
        end
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        row_d      = '0;
        state_d    = S_PROD;
      end
      S_PROD: begin
        // fetch row k while multiplying the element of row k-1
        cmd_o.fetch     = (row_q < n);
        cmd_o.mul       = (row_q != '0);
        cmd_o.mul_first = (row_q == CntW'(1));
        row_d           = row_q + CntW'(1);
        if (row_q == n) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_STEP;
      end
      S_STEP: begin
        if (sts_i.fin) begin
          cmd_o.emit = 1'b1;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.emit) begin
            row_d   = '0;
            state_d = S_PROD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      order_q  <= ORDER_RESET;
      ld_row_q <= '0;
      ld_col_q <= '0;
      row_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      order_q  <= order_d;
      ld_row_q <= ld_row_d;
      ld_col_q <= ld_col_d;
      row_q    <= row_d;
      done_q   <= done_d;
    end
  end

endmodule

// ===== design/cofactor_determinant.sv =====
// Channel   Direction  Handshake                    Payload
// request   in         start high, busy low         element_value_i
// config    in         cfg_valid_i and cfg_ready_o  cfg_data_i (order in use)
// result    out        result_valid_o, one cycle    determinant_value_o
//
// Elements load one per cycle while busy is low, row-major order.
// After the last element the determinant is summed over all n! permutations
// of the columns, one shared 50x12 multiplier taking one factor per cycle;
// each term is formed, then added or subtracted, then the sequencer steps
// to the next permutation; after the last one the result strobe follows.
// Reset clears the load position and sets the order to 4; a config write
// restarts the load. The result strobe cannot be stalled by the receiver.
module cofactor_determinant #(
  parameter int MAX_ORDER = cfd_pkg::MAX_ORDER_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [cfd_pkg::ELEM_W-1:0] element_value_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cfd_pkg::ORDER_W-1:0]       cfg_data_i,
  output logic                              result_valid_o,
  output logic signed [cfd_pkg::RES_W-1:0]  determinant_value_o
);
  import cfd_pkg::*;

  localparam int CntW = $clog2(MAX_ORDER + 1);
  localparam int IdxW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  cmd_t            cmd;
  perm_sts_t       sts;
  logic [CntW-1:0] order;
  logic [IdxW-1:0] ld_row;
  logic [IdxW-1:0] ld_col;
  logic [IdxW-1:0] rd_row;
  logic [IdxW-1:0] rd_col;
  logic            neg;

  cfd_ctrl #(
    .MAX_ORDER (MAX_ORDER),
    .CntW      (CntW),
    .IdxW      (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .order_o     (order),
    .ld_row_o    (ld_row),
    .ld_col_o    (ld_col),
    .rd_row_o    (rd_row),
    .done_o      (result_valid_o)
  );

  cfd_perm #(
    .MAX_ORDER (MAX_ORDER),
    .CntW      (CntW),
    .IdxW      (IdxW)
  ) u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .order_i (order),
    .row_i   (rd_row),
    .col_o   (rd_col),
    .neg_o   (neg),
    .sts_o   (sts)
  );

  cfd_dp #(
    .MAX_ORDER (MAX_ORDER),
    .IdxW      (IdxW)
  ) u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .element_i (element_value_i),
    .ld_row_i  (ld_row),
    .ld_col_i  (ld_col),
    .rd_row_i  (rd_row),
    .rd_col_i  (rd_col),
    .neg_i     (neg),
    .det_o     (determinant_value_o)
  );

endmodule

// ===== tb/sv/tb_cofactor_determinant.sv =====
module tb_cofactor_determinant;

  import cfd_pkg::*;

  localparam int ORD_MAX       = MAX_ORDER_DEF;
  localparam int STORE_DEPTH   = ORD_MAX * ORD_MAX;
  localparam int PERM_SPAN     = ORD_MAX ** ORD_MAX;
  localparam int RANDOM_ELEMS  = 800;
  // quiet cycles required before a config write
  localparam int SETTLE_CYCLES = 200;
  localparam int TAIL_CYCLES   = 200;
  localparam int WATCHDOG_MAX  = 4000;

  typedef enum logic [1:0] {
    REQ_ELEM,
    REQ_CFG,
    REQ_DRAIN
  } req_kind_e;

  typedef struct {
    req_kind_e        kind;
    logic [ELEM_W-1:0] value;
  } request_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_EXTREME,
    FILL_SMALL,
    FILL_SINGULAR
  } fill_style_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [ELEM_W-1:0] element_value_i = '0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [ORDER_W-1:0]       cfg_data_i = '0;
  logic                     result_valid_o;
  logic signed [RES_W-1:0]  determinant_value_o;

  // Predictor state
  logic signed [ELEM_W-1:0] elem_store [STORE_DEPTH];
  int unsigned              load_pos;
  logic [ORDER_W-1:0]       order_reg;

  request_t         request_q [$];
  logic [RES_W-1:0] det_expect_q [$];
  int               mismatch_count = 0;

  // Driver pacing
  int gap_left    = 0;
  int burst_left  = 0;
  int quiet_count = 0;
  int idle_cycles = 0;

  cofactor_determinant DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .element_value_i    (element_value_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .result_valid_o     (result_valid_o),
    .determinant_value_o(determinant_value_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned effective_order(logic [ORDER_W-1:0] v);
    if (v == 0) return 1;
    if (v > ORD_MAX) return ORD_MAX;
    return v;
  endfunction

  // Sum signed products over all column permutations of the loaded matrix
  function automatic logic [RES_W-1:0] determinant_of_store(int unsigned n);
    longint      acc;
    longint      term;
    int unsigned col_of [ORD_MAX];
    int unsigned rest;
    int unsigned inv;
    bit          ok;
    acc = 0;
    for (int code = 0; code < PERM_SPAN; code++) begin
      rest = code;
      ok   = 1'b1;
      for (int r = 0; r < ORD_MAX; r++) begin
        col_of[r] = rest % ORD_MAX;
        rest      = rest / ORD_MAX;
        if ((r < n && col_of[r] >= n) || (r >= n && col_of[r] != 0)) ok = 1'b0;
      end
      inv = 0;
      for (int i = 0; i < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (col_of[i] == col_of[j]) ok = 1'b0;
          if (col_of[i] > col_of[j]) inv++;
        end
      end
      if (ok) begin
        term = 1;
        for (int r = 0; r < n; r++) term = term * longint'(elem_store[r * ORD_MAX + col_of[r]]);
        if (inv % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
    end
    return acc[RES_W-1:0];
  endfunction

  // Store one element, queue the determinant when the matrix is complete
  function automatic void predict_element(logic signed [ELEM_W-1:0] v);
    int unsigned n;
    int unsigned cnt;
    n   = effective_order(order_reg);
    cnt = load_pos;
    if (cnt >= n * n) cnt = 0;
    elem_store[(cnt / n) * ORD_MAX + (cnt % n)] = v;
    cnt++;
    if (cnt < n * n) begin
      load_pos = cnt;
    end else begin
      det_expect_q.push_back(determinant_of_store(n));
      load_pos = 0;
    end
  endfunction

  function automatic void predict_order_write(logic [ORDER_W-1:0] v);
    order_reg = v;
    load_pos  = 0;
  endfunction

  // Mostly short gaps, a few long ones, and bursts with no gaps at all
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_elem(input logic [ELEM_W-1:0] v);
    request_t req;
    req.kind  = REQ_ELEM;
    req.value = v;
    request_q.push_back(req);
  endtask

  task automatic push_cfg(input logic [ORDER_W-1:0] v);
    request_t req;
    req.kind  = REQ_CFG;
    req.value = ELEM_W'(v);
    request_q.push_back(req);
  endtask

  task automatic push_drain();
    request_t req;
    req.kind  = REQ_DRAIN;
    req.value = '0;
    request_q.push_back(req);
  endtask

  // Queue the first cnt elements of an n x n matrix filled in the given style
  task automatic push_matrix(input int unsigned n, input fill_style_e style,
                             input int unsigned cnt);
    logic [ELEM_W-1:0] m [STORE_DEPTH];
    int                small_v;
    for (int i = 0; i < n * n; i++) begin
      case (style)
        FILL_EXTREME: begin
          case ($urandom_range(0, 4))
            0: m[i] = 12'h800;
            1: m[i] = 12'h7FF;
            2: m[i] = 12'hFFF;
            3: m[i] = 12'h000;
            default: m[i] = 12'h001;
          endcase
        end
        FILL_SMALL: begin
          small_v = int'($urandom_range(0, 6)) - 3;
          m[i]    = small_v[ELEM_W-1:0];
        end
        default: m[i] = ELEM_W'($urandom());
      endcase
    end
    // Duplicate the first row into the last to force a zero determinant
    if (style == FILL_SINGULAR && n > 1) begin
      for (int c = 0; c < n; c++) m[(n - 1) * n + c] = m[c];
    end
    for (int i = 0; i < cnt; i++) push_elem(m[i]);
  endtask

  // Driver: hold each request until taken, then pace the next one
  always @(posedge clk_i) begin : driver
    logic                     nx_start;
    logic                     nx_cfg;
    logic signed [ELEM_W-1:0] nx_elem;
    logic [ORDER_W-1:0]       nx_data;
    logic                     took_elem;
    if (rst_ni) begin
      nx_start  = start;
      nx_cfg    = cfg_valid_i;
      nx_elem   = element_value_i;
      nx_data   = cfg_data_i;
      took_elem = start && !busy;
      if (took_elem) begin
        predict_element(element_value_i);
        nx_start = 1'b0;
        gap_left = pick_gap();
      end
      if (cfg_valid_i && cfg_ready_o) begin
        predict_order_write(cfg_data_i);
        nx_cfg   = 1'b0;
        gap_left = pick_gap();
      end
      // count idle cycles since the last result went out
      if (det_expect_q.size() == 0 && !busy && !start && !took_elem) quiet_count++;
      else quiet_count = 0;
      if (!nx_start && !nx_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          case (request_q[0].kind)
            REQ_ELEM: begin
              nx_start = 1'b1;
              nx_elem  = request_q[0].value;
              void'(request_q.pop_front());
            end
            REQ_CFG: begin
              if (quiet_count >= SETTLE_CYCLES) begin
                nx_cfg  = 1'b1;
                nx_data = request_q[0].value[ORDER_W-1:0];
                void'(request_q.pop_front());
              end
            end
            default: begin
              if (det_expect_q.size() == 0) void'(request_q.pop_front());
            end
          endcase
        end
      end
      start           <= nx_start;
      cfg_valid_i     <= nx_cfg;
      element_value_i <= nx_elem;
      cfg_data_i      <= nx_data;
    end
  end

  // Monitor: compare each result strobe with the oldest expected determinant
  always @(posedge clk_i) begin : monitor
    logic [RES_W-1:0] want;
    if (rst_ni && result_valid_o) begin
      if (det_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected determinant %0d",
                                  $signed(determinant_value_o)));
      end else begin
        want = det_expect_q.pop_front();
        if (determinant_value_o !== want) begin
          report_mismatch($sformatf("determinant_value got %0d expected %0d",
                                    $signed(determinant_value_o), $signed(want)));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || result_valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int          hadamard [STORE_DEPTH];
    int unsigned elem_total;
    int unsigned phase;
    int unsigned n;
    int unsigned mats;
    logic [ORDER_W-1:0] ord;
    hadamard = '{1, 1, 1, 1, 1, -1, 1, -1, 1, 1, -1, -1, 1, -1, -1, 1};
    for (int i = 0; i < STORE_DEPTH; i++) elem_store[i] = '0;
    load_pos  = 0;
    order_reg = ORDER_RESET;

    // Reset order: sign pattern at full scale for a near-maximal determinant
    for (int i = 0; i < STORE_DEPTH; i++) push_elem(hadamard[i] > 0 ? 12'h7FF : 12'h800);
    push_drain();
    // Order zero acts as order one
    push_cfg(3'd0);
    push_elem(12'h800);
    push_elem(12'h7FF);
    push_elem(12'h000);
    push_cfg(3'd2);
    push_elem(12'h7FF);
    push_elem(12'h800);
    push_elem(12'h800);
    push_elem(12'h7FF);
    // Partial load, then an oversized order that saturates and drops it
    push_cfg(3'd3);
    push_elem(12'h123);
    push_elem(12'hEDC);
    push_cfg(3'd7);

    // Random phases, each one order setting with one or more matrices
    elem_total = 0;
    phase      = 0;
    while (elem_total < RANDOM_ELEMS) begin
      ord = (phase < 8) ? ORDER_W'(phase) : ORDER_W'($urandom_range(0, 7));
      if (phase > 0) push_cfg(ord);
      n    = effective_order(ord);
      mats = (n == ORD_MAX) ? $urandom_range(1, 3) : $urandom_range(2, 8);
      for (int k = 0; k < mats; k++) begin
        push_matrix(n, fill_style_e'($urandom_range(0, 5) > 3 ?
                    $urandom_range(1, 3) : FILL_RANDOM), n * n);
        elem_total += n * n;
        if ($urandom_range(0, 5) == 0) push_drain();
      end
      // Leave a partial matrix for the next order write to discard
      if (n > 1 && $urandom_range(0, 5) == 0) begin
        mats = $urandom_range(1, n * n - 1);
        push_matrix(n, FILL_RANDOM, mats);
        elem_total += mats;
      end
      phase++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || start || cfg_valid_i) @(posedge clk_i);
    while (det_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cfd_pkg.sv
design/cfd_perm.sv
design/cfd_dp.sv
design/cfd_ctrl.sv
design/cofactor_determinant.sv
tb/sv/tb_cofactor_determinant.sv
